### rtl/opc_pkg.sv
// Package for the OTA packet checker: payload types, status and reply codes, constants.
package opc_pkg;

   localparam int unsigned PACKET_BYTES_MAX_DEFAULT = 512;
   localparam int unsigned CHUNK_STRIDE             = 392;

   localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
   localparam logic [7:0]  SYNC_SECOND = 8'h55;

   localparam logic [31:0] SETTINGS_SLOT1 = 32'hFFFF_FFFF;
   localparam logic [31:0] SETTINGS_SLOT0 = 32'h0000_0000;
   localparam logic [31:0] SLOT0_BASE_RESET = 32'h0800_2000;
   localparam logic [31:0] SLOT1_BASE_RESET = 32'h0802_1000;

   localparam logic [6:0]  PAGE_SLOT1 = 7'd66;
   localparam logic [6:0]  PAGE_SLOT0 = 7'd4;

   localparam int unsigned FIELD_BYTES         = 7;
   localparam int unsigned HEADER_PACKET_BYTES = 17;
   localparam int unsigned STAGED_FIRST        = 11;
   localparam int unsigned STAGED_BYTES        = 6;

   localparam logic [2:0] ST_NOT_PACKET     = 3'd0;
   localparam logic [2:0] ST_HEADER_OK      = 3'd1;
   localparam logic [2:0] ST_CHUNK_OK       = 3'd2;
   localparam logic [2:0] ST_CHECKSUM_ERROR = 3'd3;
   localparam logic [2:0] ST_SEQUENCE_LOST  = 3'd4;
   localparam logic [2:0] ST_TRUNCATED      = 3'd5;

   localparam logic [1:0] REPLY_NONE = 2'd0;
   localparam logic [1:0] REPLY_ACK  = 2'd1;
   localparam logic [1:0] REPLY_NAK  = 2'd2;

   localparam logic [1:0] CSR_SETTINGS_WORD = 2'd0;
   localparam logic [1:0] CSR_SLOT0_BASE    = 2'd1;
   localparam logic [1:0] CSR_SLOT1_BASE    = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } opc_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  reply_code;
      logic [15:0] packet_index;
      logic [15:0] next_expected;
      logic [31:0] write_address;
      logic [15:0] write_length;
      logic        erase_request;
      logic [6:0]  erase_first_page;
      logic [31:0] total_length;
      logic [15:0] image_crc;
   } opc_rsp_type;

endpackage

### rtl/ota_packet_checker_core.sv
// OTA packet checker: parses update packets byte by byte and reports one result per packet.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   req     | in        | req_valid/req_stall  | opc_req_type (byte, last flag)
//   rsp     | out       | rsp_valid/rsp_stall  | opc_rsp_type (packet result)
//   csr     | in        | csr_write_enable     | csr_index, csr_write_data
//
// One byte is taken every cycle unless req stalls. On its last byte a packet's result
// is registered into the result register, or into the skid if rsp stalls. Reset is
// synchronous and restores the register defaults and clears all packet and sequence
// state. The one-entry skid holds a second result, so req stalls only while it is full.
module ota_packet_checker_core #(
   parameter int unsigned PACKET_BYTES_MAX = opc_pkg::PACKET_BYTES_MAX_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  opc_pkg::opc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output opc_pkg::opc_rsp_type rsp_data,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_write_data
);

   localparam int unsigned POS_W    = $clog2(PACKET_BYTES_MAX + 1);
   localparam int unsigned STRIDE_W = $clog2(opc_pkg::CHUNK_STRIDE + 1);
   localparam int unsigned OFFS_W   = 16 + STRIDE_W;

   logic [31:0] settings_ff, slot0_base_ff, slot1_base_ff;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             hbad_ff, hbad_in;
   logic [15:0]      idx_ff, idx_in;
   logic [15:0]      len_ff, len_in;
   logic [7:0]       chk_ff, chk_in;
   logic [7:0]       xor_ff, xor_in;
   logic [47:0]      staged_ff, staged_in;

   logic [15:0]      expected_ff, expected_in;
   logic [31:0]      write_base_ff, write_base_in;
   logic [31:0]      total_ff, total_in;
   logic [15:0]      crc_ff, crc_in;

   opc_pkg::opc_rsp_type rsp_ff, skid_ff, rsp_new;
   logic                 rsp_valid_ff, skid_valid_ff;

   logic             accept, finish, take;
   logic [7:0]       b;
   logic [POS_W-1:0] p;
   logic [7:0]       sum;
   logic [OFFS_W-1:0] chunk_offset;
   logic             out_free;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign finish    = accept && req_data.last_byte;
   assign b         = req_data.data_byte;
   assign p         = pos_ff;

   // per-byte field capture
   always_comb begin
      take      = (p < POS_W'(PACKET_BYTES_MAX));
      pos_in    = pos_ff;
      hbad_in   = hbad_ff;
      idx_in    = idx_ff;
      len_in    = len_ff;
      chk_in    = chk_ff;
      xor_in    = xor_ff;
      staged_in = staged_ff;
      if (take) begin
         pos_in = p + POS_W'(1);
         if (p == POS_W'(0) && b != opc_pkg::SYNC_FIRST)  hbad_in = 1'b1;
         if (p == POS_W'(1) && b != opc_pkg::SYNC_SECOND) hbad_in = 1'b1;
         if (p == POS_W'(2)) idx_in[15:8] = b;
         if (p == POS_W'(3)) idx_in[7:0]  = b;
         if (p == POS_W'(4)) len_in[15:8] = b;
         if (p == POS_W'(5)) len_in[7:0]  = b;
         if (p == POS_W'(6)) chk_in       = b;
         for (int i = 0; i < opc_pkg::STAGED_BYTES; i++) begin
            if (p == POS_W'(opc_pkg::STAGED_FIRST + i)) staged_in[47 - 8*i -: 8] = b;
         end
         if (p >= POS_W'(opc_pkg::FIELD_BYTES) &&
             17'(p - POS_W'(opc_pkg::FIELD_BYTES)) < {1'b0, len_ff}) begin
            xor_in = xor_ff ^ b;
         end
      end
   end

   assign chunk_offset = {{STRIDE_W{1'b0}}, expected_ff} *
                         {16'd0, STRIDE_W'(opc_pkg::CHUNK_STRIDE)};
   assign sum = (len_in == 16'd1) ? ~xor_in : xor_in;

   // packet decision on the last byte
   always_comb begin
      rsp_new       = '0;
      expected_in   = expected_ff;
      write_base_in = write_base_ff;
      total_in      = total_ff;
      crc_in        = crc_ff;
      rsp_new.status     = opc_pkg::ST_NOT_PACKET;
      rsp_new.reply_code = opc_pkg::REPLY_NONE;
      if (!hbad_in) begin
         rsp_new.packet_index = idx_in;
         if (pos_in < POS_W'(opc_pkg::FIELD_BYTES)) begin
            rsp_new.status = opc_pkg::ST_TRUNCATED;
         end else if (idx_in == 16'd0) begin
            if (pos_in < POS_W'(opc_pkg::HEADER_PACKET_BYTES)) begin
               rsp_new.status = opc_pkg::ST_TRUNCATED;
            end else begin
               rsp_new.status     = opc_pkg::ST_HEADER_OK;
               rsp_new.reply_code = opc_pkg::REPLY_ACK;
               total_in    = staged_in[47:16];
               crc_in      = staged_in[15:0];
               expected_in = 16'd0;
               if (settings_ff == opc_pkg::SETTINGS_SLOT1) begin
                  rsp_new.erase_request    = 1'b1;
                  rsp_new.erase_first_page = opc_pkg::PAGE_SLOT1;
                  write_base_in            = slot1_base_ff;
               end else if (settings_ff == opc_pkg::SETTINGS_SLOT0) begin
                  rsp_new.erase_request    = 1'b1;
                  rsp_new.erase_first_page = opc_pkg::PAGE_SLOT0;
                  write_base_in            = slot0_base_ff;
               end
            end
         end else if ({1'b0, idx_in} == {1'b0, expected_ff} + 17'd1) begin
            if (17'(pos_in) < {1'b0, len_in} + 17'(opc_pkg::FIELD_BYTES)) begin
               rsp_new.status = opc_pkg::ST_TRUNCATED;
            end else if (sum == chk_in) begin
               rsp_new.status        = opc_pkg::ST_CHUNK_OK;
               rsp_new.reply_code    = opc_pkg::REPLY_ACK;
               rsp_new.write_address = write_base_ff + 32'(chunk_offset);
               rsp_new.write_length  = len_in;
               expected_in           = idx_in;
            end else begin
               rsp_new.status = opc_pkg::ST_CHECKSUM_ERROR;
            end
         end else begin
            rsp_new.status     = opc_pkg::ST_SEQUENCE_LOST;
            rsp_new.reply_code = opc_pkg::REPLY_NAK;
         end
      end
      rsp_new.next_expected = expected_in;
      rsp_new.total_length  = total_in;
      rsp_new.image_crc     = crc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settings_ff   <= opc_pkg::SETTINGS_SLOT1;
         slot0_base_ff <= opc_pkg::SLOT0_BASE_RESET;
         slot1_base_ff <= opc_pkg::SLOT1_BASE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            opc_pkg::CSR_SETTINGS_WORD: settings_ff   <= csr_write_data;
            opc_pkg::CSR_SLOT0_BASE:    slot0_base_ff <= csr_write_data;
            opc_pkg::CSR_SLOT1_BASE:    slot1_base_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         hbad_ff   <= 1'b0;
         idx_ff    <= '0;
         len_ff    <= '0;
         chk_ff    <= '0;
         xor_ff    <= '0;
         staged_ff <= '0;
      end else if (finish) begin
         pos_ff    <= '0;
         hbad_ff   <= 1'b0;
         idx_ff    <= '0;
         len_ff    <= '0;
         chk_ff    <= '0;
         xor_ff    <= '0;
         staged_ff <= '0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         hbad_ff   <= hbad_in;
         idx_ff    <= idx_in;
         len_ff    <= len_in;
         chk_ff    <= chk_in;
         xor_ff    <= xor_in;
         staged_ff <= staged_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff   <= '0;
         write_base_ff <= '0;
         total_ff      <= '0;
         crc_ff        <= '0;
      end else if (finish) begin
         expected_ff   <= expected_in;
         write_base_ff <= write_base_in;
         total_ff      <= total_in;
         crc_ff        <= crc_in;
      end
   end

   // result register with one-entry skid
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff  <= skid_valid_ff || finish;
         skid_valid_ff <= 1'b0;
      end else if (finish) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_ff <= skid_valid_ff ? skid_ff : rsp_new;
      end
      if (!out_free && finish) begin
         skid_ff <= rsp_new;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
